// ===== rtl/core/cfs_pkg.sv =====
// Package for the circular FIFO with search: sizes, command and status codes,
// request and response structs, cell link types, controller states and the
// slot-count clamp. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfs_pkg;

   localparam int DEPTH      = 16;
   localparam int NUM_CELLS  = DEPTH - 1;
   localparam int CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int ELEM_W     = 32;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [SLOT_W-1:0] SLOTS_RESET = 5'd16;
   localparam logic [SLOT_W-1:0] SLOTS_MIN   = 5'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [ELEM_W-1:0] element;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [ELEM_W-1:0] data;
      logic                     found;
   } rsp_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                     clear;
      logic                     shift;
      logic                     insert;
      logic signed [ELEM_W-1:0] new_element;
   } cell_ctrl_type;

   // Search probe handed from one cell to the next.
   typedef struct packed {
      logic signed [ELEM_W-1:0] key;
      logic                     probe;
      logic                     hit;
   } probe_link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   function automatic logic [SLOT_W-1:0] clamp_slots(input logic [SLOT_W-1:0] raw);
      logic [SLOT_W-1:0] v;
      v = raw;
      if (v < SLOTS_MIN) v = SLOTS_MIN;
      if (int'(v) > DEPTH) v = SLOT_W'(DEPTH);
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/circular_fifo_with_search.sv =====
// Top level of the circular FIFO with search: the controller and a chain of
// storage cells. Depends on cfs_pkg, cfs_ctrl and cfs_cell.
//
// Usage: requests enter on the req_ channel (valid/ready) with a command and
// an element; each request yields exactly one response on the rsp_ channel.
// Insert appends at the newest end or reports full; remove returns the oldest
// element or reports empty; search reports whether the value is stored.
// Insert, remove and unused commands answer in the cycle after acceptance.
// A search walks a probe down the cell chain one cell per cycle. Once it leaves
// the last cell, the hit is registered in the controller and then loaded into
// the response register. No new request is taken while a search is in flight.
// The response sits in an output register; while the receiver stalls it holds,
// and a new request is taken only in the cycle that register drains or is free.
// Reset empties the queue and sets the slot count to 16. A csr_ write sets the
// slot count (clamped to 2..16, capacity one less) and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module circular_fifo_with_search (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire cfs_pkg::req_type           req,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output cfs_pkg::rsp_type                rsp,
   input  wire logic                       csr_write_enable,
   input  wire logic [cfs_pkg::SLOT_W-1:0] csr_write_data
);
   import cfs_pkg::*;

   cell_ctrl_type            cell_ctrl;
   logic [NUM_CELLS-1:0]     valid_vec;
   logic signed [ELEM_W-1:0] element_w [NUM_CELLS];
   probe_link_type           link_w [NUM_CELLS+1];

   cfs_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req              (req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .valid_vec        (valid_vec),
      .head_element     (element_w[0]),
      .tail_link        (link_w[NUM_CELLS]),
      .cell_ctrl        (cell_ctrl),
      .launch_link      (link_w[0])
   );

   // Cell 0 holds the oldest element. A remove shifts every cell toward
   // cell 0; an insert lands in the first empty cell.
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      logic                     prev_valid;
      logic                     next_valid;
      logic signed [ELEM_W-1:0] next_element;

      if (k == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_mid
         assign prev_valid = valid_vec[k-1];
      end

      if (k == NUM_CELLS - 1) begin : g_last
         assign next_valid   = 1'b0;
         assign next_element = '0;
      end else begin : g_inner
         assign next_valid   = valid_vec[k+1];
         assign next_element = element_w[k+1];
      end

      cfs_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl_i         (cell_ctrl),
         .prev_valid_i   (prev_valid),
         .next_valid_i   (next_valid),
         .next_element_i (next_element),
         .link_i         (link_w[k]),
         .valid_o        (valid_vec[k]),
         .element_o      (element_w[k]),
         .link_o         (link_w[k+1])
      );
   end

endmodule

`default_nettype wire

// ===== rtl/core/cfs_cell.sv =====
// One storage cell of the FIFO chain: holds one element with its valid bit
// and one stage of the search probe pipeline. Depends on cfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfs_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cfs_pkg::cell_ctrl_type          ctrl_i,
   input  wire logic                            prev_valid_i,
   input  wire logic                            next_valid_i,
   input  wire logic signed [cfs_pkg::ELEM_W-1:0] next_element_i,
   input  wire cfs_pkg::probe_link_type         link_i,
   output logic                                 valid_o,
   output logic signed [cfs_pkg::ELEM_W-1:0]    element_o,
   output cfs_pkg::probe_link_type              link_o
);
   import cfs_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [ELEM_W-1:0] element_ff, element_in;
   logic                     probe_ff, probe_in;
   logic signed [ELEM_W-1:0] key_ff, key_in;
   logic                     hit_ff, hit_in;
   logic                     take_new;

   // The first free cell behind the occupied ones takes an inserted element.
   assign take_new = ctrl_i.insert && !valid_ff && prev_valid_i;

   always_comb begin
      valid_in   = valid_ff;
      element_in = element_ff;
      if (ctrl_i.clear) begin
         valid_in = 1'b0;
      end else if (ctrl_i.shift) begin
         valid_in   = next_valid_i;
         element_in = next_element_i;
      end else if (take_new) begin
         valid_in   = 1'b1;
         element_in = ctrl_i.new_element;
      end
   end

   assign probe_in = link_i.probe;
   assign key_in   = link_i.key;
   assign hit_in   = link_i.hit || (link_i.probe && valid_ff && (element_ff == link_i.key));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         probe_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      element_ff <= element_in;
      key_ff     <= key_in;
      hit_ff     <= hit_in;
   end

   assign valid_o   = valid_ff;
   assign element_o = element_ff;
   assign link_o    = '{key: key_ff, probe: probe_ff, hit: hit_ff};

endmodule

`default_nettype wire

// ===== rtl/core/cfs_ctrl.sv =====
// Controller of the FIFO chain: request decode, full and empty checks,
// search sequencing and the response register. Depends on cfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfs_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire cfs_pkg::req_type                  req,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output cfs_pkg::rsp_type                       rsp,
   input  wire logic                              csr_write_enable,
   input  wire logic [cfs_pkg::SLOT_W-1:0]        csr_write_data,
   input  wire logic [cfs_pkg::NUM_CELLS-1:0]     valid_vec,
   input  wire logic signed [cfs_pkg::ELEM_W-1:0] head_element,
   input  wire cfs_pkg::probe_link_type           tail_link,
   output cfs_pkg::cell_ctrl_type                 cell_ctrl,
   output cfs_pkg::probe_link_type                launch_link
);
   import cfs_pkg::*;

   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    slots_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 found_ff;
   logic                 out_free;
   logic                 accept;
   logic                 full;
   logic                 empty;
   logic                 load_now;
   logic                 load_search;
   logic [CELL_IDX_W-1:0] cap_idx;

   // Capacity is slots - 1, so the queue is full once cell slots - 2 holds data.
   assign cap_idx  = CELL_IDX_W'(slots_ff - SLOTS_MIN);
   assign full     = valid_vec[cap_idx];
   assign empty    = !valid_vec[0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.command == CMD_SEARCH)) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (tail_link.probe) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      load_search = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready   = out_free;
         ST_SEARCH: req_ready   = 1'b0;
         ST_DONE:   load_search = out_free;
         default:   req_ready   = 1'b0;
      endcase
   end

   assign load_now = accept && (req.command != CMD_SEARCH);

   always_comb begin
      cell_ctrl.clear       = csr_write_enable;
      cell_ctrl.shift       = accept && (req.command == CMD_REMOVE) && !empty;
      cell_ctrl.insert      = accept && (req.command == CMD_INSERT) && !full;
      cell_ctrl.new_element = req.element;
      launch_link.key       = req.element;
      launch_link.probe     = accept && (req.command == CMD_SEARCH);
      launch_link.hit       = 1'b0;
   end

   always_comb begin
      rsp_in = '{status: STATUS_OK, data: '0, found: 1'b0};
      if (load_search) begin
         rsp_in.found = found_ff;
      end else begin
         case (req.command)
            CMD_INSERT: begin
               if (full) rsp_in.status = STATUS_FULL;
            end
            CMD_REMOVE: begin
               if (empty) rsp_in.status = STATUS_EMPTY;
               else       rsp_in.data   = head_element;
            end
            default: rsp_in = '{status: STATUS_OK, data: '0, found: 1'b0};
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_now || load_search) rsp_valid_in = 1'b1;
      else if (rsp_ready)          rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         slots_ff     <= clamp_slots(SLOTS_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) slots_ff <= clamp_slots(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (load_now || load_search) rsp_ff <= rsp_in;
      if ((state_ff == ST_SEARCH) && tail_link.probe) found_ff <= tail_link.hit;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cfs_checker.sv =====
// Port-level assertions for the circular FIFO with search, bound to the top
// level. Depends on cfs_pkg and circular_fifo_with_search.
`timescale 1ns / 1ps
`default_nettype none

module cfs_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire cfs_pkg::req_type           req,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire cfs_pkg::rsp_type           rsp
);
   import cfs_pkg::*;

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response changed while stalled");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // Every non-search request is answered in the next cycle.
   a_quick_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req.command != CMD_SEARCH) |=> rsp_valid)
      else $error("missing response after insert or remove");

   // An accepted search closes the request channel behind it.
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req.command == CMD_SEARCH) |=> !req_ready)
      else $error("request taken during a search");

   // A reported hit carries ok status and no data.
   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.found |-> (rsp.status == STATUS_OK) && (rsp.data == '0))
      else $error("found response with status or data set");

endmodule

bind circular_fifo_with_search cfs_checker u_cfs_checker (.*);

`default_nettype wire

// ===== dv/circular_fifo_with_search_tb.sv =====
// Self-checking testbench for circular_fifo_with_search: directed and random
// requests checked against a shadow queue kept inside the bench.
// Depends on cfs_pkg and the circular_fifo_with_search RTL.
`timescale 1ns / 1ps

module circular_fifo_with_search_tb;

   import cfs_pkg::*;

   // Command 3 has no meaning in the block; it must leave the queue alone.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int DIRECTED_ROWS = 24;
   localparam int ITEMS_PER_BLOCK = 100;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef enum logic {ROW_REQUEST, ROW_SLOTS} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      req_type           request;
      logic [SLOT_W-1:0] slots;
      logic              typed;
      rsp_type           response;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_write_enable = 1'b0;
   logic [SLOT_W-1:0] csr_write_data = '0;

   int unsigned sender_idle_pct = 20;
   int unsigned receiver_stall_pct = 73;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Shadow copy of the ring, its indexes and the slot count in use.
   logic signed [ELEM_W-1:0] shadow_ring [DEPTH];
   logic [3:0]               shadow_head = '0;
   logic [3:0]               shadow_tail = '0;
   logic [SLOT_W-1:0]        shadow_slots = 5'd16;

   rsp_type      awaited_responses [$];
   rsp_type      oldest_expected;
   stim_row_type directed_rows [DIRECTED_ROWS];

   circular_fifo_with_search dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req              (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [3:0] next_slot(input logic [3:0] i);
      logic [SLOT_W-1:0] n;
      n = {1'b0, i} + 5'd1;
      return (n >= shadow_slots) ? 4'd0 : n[3:0];
   endfunction

   // Applies one request to the shadow queue and returns the response it must get.
   function automatic rsp_type step_shadow_queue(input req_type r);
      rsp_type    resp;
      logic [3:0] n;
      logic [3:0] i;
      resp = '0;
      resp.status = STATUS_OK;
      case (r.command)
         CMD_INSERT: begin
            n = next_slot(shadow_tail);
            if (n == shadow_head) begin
               resp.status = STATUS_FULL;
            end else begin
               shadow_tail = n;
               shadow_ring[n] = r.element;
            end
         end
         CMD_REMOVE: begin
            if (shadow_head == shadow_tail) begin
               resp.status = STATUS_EMPTY;
            end else begin
               n = next_slot(shadow_head);
               resp.data = shadow_ring[n];
               // Taking the last element rewinds both indexes to slot zero.
               if (n == shadow_tail) begin
                  shadow_head = '0;
                  shadow_tail = '0;
               end else begin
                  shadow_head = n;
               end
            end
         end
         CMD_SEARCH: begin
            i = shadow_head;
            for (int k = 0; k < DEPTH; k++) begin
               if (i == shadow_tail) break;
               i = next_slot(i);
               if (shadow_ring[i] == r.element) begin
                  resp.found = 1'b1;
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      return resp;
   endfunction

   function automatic stim_row_type request_row(input logic [CMD_W-1:0] cmd,
                                                input logic signed [ELEM_W-1:0] value,
                                                input logic typed,
                                                input logic [STATUS_W-1:0] status,
                                                input logic signed [ELEM_W-1:0] data,
                                                input logic found);
      stim_row_type row;
      row = '0;
      row.kind = ROW_REQUEST;
      row.request.command = cmd;
      row.request.element = value;
      row.typed = typed;
      row.response.status = status;
      row.response.data = data;
      row.response.found = found;
      return row;
   endfunction

   function automatic stim_row_type slots_row(input logic [SLOT_W-1:0] raw);
      stim_row_type row;
      row = '0;
      row.kind = ROW_SLOTS;
      row.slots = raw;
      return row;
   endfunction

   // Offers one request, holding it until accepted. At the accepting edge the
   // shadow queue advances and the response to wait for is queued. A typed
   // row supplies that response itself; the shadow queue still has to advance.
   task automatic send_request(input req_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = step_shadow_queue(r);
      awaited_responses.push_back(typed ? typed_rsp : predicted);
   endtask

   // A slot count is only written once the block has answered everything.
   // Every request yields a response, so a short pause after that suffices.
   task automatic write_slots(input logic [SLOT_W-1:0] raw);
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= raw;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      // Out-of-range counts saturate to 2..DEPTH, and any write empties the queue.
      if (raw < 5'd2) shadow_slots = 5'd2;
      else if (int'(raw) > DEPTH) shadow_slots = SLOT_W'(DEPTH);
      else shadow_slots = raw;
      shadow_head = '0;
      shadow_tail = '0;
   endtask

   // Response side: random stalls, and every accepted response is compared
   // field by field with the oldest one still awaited.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t: unexpected response status %0d data %0d found %0d",
                        $time, rsp_payload.status, rsp_payload.data, rsp_payload.found);
               error_count++;
            end else begin
               oldest_expected = awaited_responses.pop_front();
               if (rsp_payload.status !== oldest_expected.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           oldest_expected.status, rsp_payload.status);
                  error_count++;
               end
               if (rsp_payload.data !== oldest_expected.data) begin
                  $display("%0t: data expected %0d actual %0d", $time,
                           oldest_expected.data, rsp_payload.data);
                  error_count++;
               end
               if (rsp_payload.found !== oldest_expected.found) begin
                  $display("%0t: found expected %0d actual %0d", $time,
                           oldest_expected.found, rsp_payload.found);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[circular_fifo_with_search] ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned       phase;
      int unsigned       blk;
      int unsigned       item;
      int unsigned       roll;
      int unsigned       pick;
      int                count;
      logic              fill_bias;
      logic [3:0]        idx;
      logic [CMD_W-1:0]  cmd;
      logic signed [ELEM_W-1:0] value;
      logic [SLOT_W-1:0] slot_plan [12];
      req_type           r;

      // Directed rows: empty queue after reset, field extremes, the unused
      // command, the old empty sentinel as plain data, saturated slot counts,
      // a full queue at the smallest ring and rewind on the last removal.
      directed_rows[0]  = request_row(CMD_SEARCH, 32'sd0, 1'b1, STATUS_OK, 32'sd0, 1'b0);
      directed_rows[1]  = request_row(CMD_REMOVE, -32'sd1, 1'b1, STATUS_EMPTY, 32'sd0, 1'b0);
      directed_rows[2]  = request_row(CMD_UNUSED, -32'sd1, 1'b1, STATUS_OK, 32'sd0, 1'b0);
      directed_rows[3]  = request_row(CMD_INSERT, 32'sh7FFFFFFF, 1'b1, STATUS_OK, 32'sd0, 1'b0);
      directed_rows[4]  = request_row(CMD_INSERT, 32'sh80000000, 1'b1, STATUS_OK, 32'sd0, 1'b0);
      directed_rows[5]  = request_row(CMD_INSERT, -32'sd5555, 1'b1, STATUS_OK, 32'sd0, 1'b0);
      directed_rows[6]  = request_row(CMD_SEARCH, -32'sd5555, 1'b0, '0, '0, 1'b0);
      directed_rows[7]  = request_row(CMD_SEARCH, 32'sh80000000, 1'b0, '0, '0, 1'b0);
      directed_rows[8]  = request_row(CMD_SEARCH, 32'sd0, 1'b0, '0, '0, 1'b0);
      directed_rows[9]  = request_row(CMD_REMOVE, 32'sd0, 1'b1, STATUS_OK, 32'sh7FFFFFFF, 1'b0);
      directed_rows[10] = request_row(CMD_UNUSED, 32'sd0, 1'b0, '0, '0, 1'b0);
      directed_rows[11] = request_row(CMD_REMOVE, 32'sd0, 1'b1, STATUS_OK, 32'sh80000000, 1'b0);
      directed_rows[12] = request_row(CMD_REMOVE, 32'sd0, 1'b0, '0, '0, 1'b0);
      directed_rows[13] = request_row(CMD_REMOVE, 32'sd0, 1'b1, STATUS_EMPTY, 32'sd0, 1'b0);
      directed_rows[14] = request_row(CMD_INSERT, 32'sd5, 1'b0, '0, '0, 1'b0);
      directed_rows[15] = slots_row(5'd0);
      directed_rows[16] = request_row(CMD_SEARCH, 32'sd5, 1'b0, '0, '0, 1'b0);
      directed_rows[17] = request_row(CMD_INSERT, -32'sd1, 1'b0, '0, '0, 1'b0);
      directed_rows[18] = request_row(CMD_INSERT, 32'sd7, 1'b1, STATUS_FULL, 32'sd0, 1'b0);
      directed_rows[19] = request_row(CMD_SEARCH, -32'sd1, 1'b0, '0, '0, 1'b0);
      directed_rows[20] = request_row(CMD_REMOVE, 32'sd0, 1'b0, '0, '0, 1'b0);
      directed_rows[21] = request_row(CMD_REMOVE, 32'sd0, 1'b0, '0, '0, 1'b0);
      directed_rows[22] = slots_row(5'd31);
      directed_rows[23] = request_row(CMD_INSERT, 32'sd0, 1'b0, '0, '0, 1'b0);

      // Slot counts for the random blocks, including both saturating ends.
      slot_plan = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd7, 5'd0,
                    5'd17, 5'd3, 5'd12, 5'd16, 5'd5, 5'd9};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         if (directed_rows[n].kind == ROW_SLOTS) begin
            write_slots(directed_rows[n].slots);
         end else begin
            send_request(directed_rows[n].request, directed_rows[n].typed,
                         directed_rows[n].response);
         end
      end

      // Random part: three idle patterns, four slot counts each. The command
      // mix swings between filling and draining so the queue keeps reaching
      // both full and empty, and searches often target a stored element.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 20;
               receiver_stall_pct = 73;
            end
            1: begin
               sender_idle_pct = 73;
               receiver_stall_pct = 20;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         for (blk = 0; blk < 4; blk++) begin
            write_slots(slot_plan[phase * 4 + blk]);
            fill_bias = 1'b1;
            for (item = 0; item < ITEMS_PER_BLOCK; item++) begin
               if (item % 20 == 0 && item != 0) fill_bias = 1'($urandom_range(1));
               roll = $urandom_range(99);
               if (roll >= 97) cmd = CMD_UNUSED;
               else if (roll < (fill_bias ? 55 : 20)) cmd = CMD_INSERT;
               else if (roll < (fill_bias ? 75 : 60)) cmd = CMD_REMOVE;
               else cmd = CMD_SEARCH;

               pick = $urandom_range(9);
               if (pick < 3) value = int'($urandom_range(4)) - 2;
               else if (pick == 3) value = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
               else if (pick == 4) value = -32'sd5555;
               else value = $urandom;

               count = (int'(shadow_tail) + int'(shadow_slots) - int'(shadow_head))
                       % int'(shadow_slots);
               if (cmd == CMD_SEARCH && count > 0 && $urandom_range(99) < 55) begin
                  idx = shadow_head;
                  repeat ($urandom_range(count, 1)) idx = next_slot(idx);
                  value = shadow_ring[idx];
               end

               r.command = cmd;
               r.element = value;
               send_request(r, 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      // Any stray response after the last expected one is caught here.
      repeat (25) @(posedge clock);
      if (error_count == 0) begin
         $display("[circular_fifo_with_search] OK");
      end else begin
         $display("[circular_fifo_with_search] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cfs_pkg.sv
rtl/core/cfs_cell.sv
rtl/core/cfs_ctrl.sv
rtl/core/circular_fifo_with_search.sv
rtl/core/cfs_checker.sv
dv/circular_fifo_with_search_tb.sv
